/* rtl/core/mch_pkg.sv */
package mch_pkg;

  localparam int ID_W            = 30;
  localparam int CODE_W          = 10;
  localparam int PERIOD_W        = 16;
  localparam int OUT_COUNT_W     = 32;
  localparam int NUM_CODES_DEF   = 1024;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int PROD_W          = 62;
  localparam int SHIFT_W         = 6;

  localparam logic [ID_W-1:0] CODE_LIMIT = 30'd1000;
  localparam logic [ID_W-1:0] LIM_DIV100 = 30'd100000;
  localparam logic [ID_W-1:0] LIM_DIV1K  = 30'd1000000;

  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP_100  = 32'h51EB_851F;
  localparam logic [31:0] RECIP_1000 = 32'h1062_4DD3;

  localparam logic [SHIFT_W-1:0] SHIFT_10   = 6'd35;
  localparam logic [SHIFT_W-1:0] SHIFT_100  = 6'd37;
  localparam logic [SHIFT_W-1:0] SHIFT_1000 = 6'd38;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd20;
  localparam logic [63:0]         OUT_COUNT_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic  valid;
    code_t code;
  } code_push_t;

  typedef struct packed {
    logic  avail;
    code_t code;
  } code_head_t;

endpackage

/* rtl/core/mch_ram.sv */
module mch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/mch_front.sv */
module mch_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         hold,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mch_pkg::ID_W-1:0]     vessel_id,
  input  logic                         queue_full,
  output mch_pkg::code_push_t          push
);

  logic                          busy;
  logic                          busy_next;
  logic [mch_pkg::ID_W-1:0]      value;
  logic [mch_pkg::ID_W-1:0]      value_next;
  logic [31:0]                   recip;
  logic [mch_pkg::SHIFT_W-1:0]   shift;
  logic [mch_pkg::PROD_W-1:0]    prod;
  logic                          accept;
  logic                          done;

  assign in_stall = busy | hold;
  assign accept   = in_valid & ~in_stall;
  assign done     = busy & (value < mch_pkg::CODE_LIMIT);

  assign push.valid = done & ~queue_full;
  assign push.code  = mch_pkg::CODE_W'(value);

  always_comb begin
    if (value >= mch_pkg::LIM_DIV1K) begin
      recip = mch_pkg::RECIP_1000;
      shift = mch_pkg::SHIFT_1000;
    end else if (value >= mch_pkg::LIM_DIV100) begin
      recip = mch_pkg::RECIP_100;
      shift = mch_pkg::SHIFT_100;
    end else begin
      recip = mch_pkg::RECIP_10;
      shift = mch_pkg::SHIFT_10;
    end
    prod = mch_pkg::PROD_W'(value) * mch_pkg::PROD_W'(recip);
  end

  always_comb begin
    busy_next  = busy;
    value_next = value;
    if (accept) begin
      busy_next  = 1'b1;
      value_next = vessel_id;
    end else if (push.valid) begin
      busy_next = 1'b0;
    end else if (busy && !done) begin
      value_next = mch_pkg::ID_W'(prod >> shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
    value <= value_next;
  end

endmodule

/* rtl/core/mch_queue.sv */
module mch_queue (
  input  logic                clk,
  input  logic                rst,
  input  mch_pkg::code_push_t push,
  output logic                full,
  input  logic                pop,
  output mch_pkg::code_head_t head
);

  localparam int PW = (mch_pkg::QUEUE_DEPTH > 1) ? $clog2(mch_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(mch_pkg::QUEUE_DEPTH + 1);

  mch_pkg::code_t  slots [mch_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    if (p == PW'(mch_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full       = (fill == CW'(mch_pkg::QUEUE_DEPTH));
  assign head.avail = (fill != '0);
  assign head.code  = slots[rd_ptr];
  assign do_push    = push.valid & ~full;
  assign do_pop     = pop & head.avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push.code;
    end
  end

endmodule

/* rtl/core/mch_back.sv */
module mch_back #(
  parameter int NUM_CODES   = mch_pkg::NUM_CODES_DEF,
  parameter int COUNT_WIDTH = mch_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mch_pkg::PERIOD_W-1:0]    report_period,
  input  mch_pkg::code_head_t             head,
  output logic                            pop,
  output logic                            clearing,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mch_pkg::CODE_W-1:0]      country_code,
  output logic                            report_valid,
  output logic [mch_pkg::CODE_W-1:0]      mode_code,
  output logic [mch_pkg::OUT_COUNT_W-1:0] mode_count
);

  localparam int AW = $clog2(NUM_CODES);
  localparam logic S_FETCH  = 1'b0;
  localparam logic S_UPDATE = 1'b1;

  logic                          state;
  logic [AW-1:0]                 clr_addr;
  mch_pkg::code_t                cur_code;
  logic [mch_pkg::PERIOD_W-1:0]  period_counter;
  logic [mch_pkg::PERIOD_W-1:0]  period_counter_next;
  mch_pkg::code_t                best_code;
  mch_pkg::code_t                best_code_next;
  logic [COUNT_WIDTH-1:0]        best_count;
  logic [COUNT_WIDTH-1:0]        best_count_next;
  logic [COUNT_WIDTH-1:0]        count_rd;
  logic [COUNT_WIDTH-1:0]        count_new;
  logic                          saturated;
  logic                          slot_free;
  logic                          finish;
  logic                          report;
  logic [mch_pkg::PERIOD_W-1:0]  period_inc;
  logic [mch_pkg::OUT_COUNT_W-1:0] mode_count_sat;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [COUNT_WIDTH-1:0]        ram_wdata;

  mch_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_CODES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (AW'(head.code)),
    .rdata (count_rd)
  );

  assign pop       = (state == S_FETCH) & ~clearing & head.avail;
  assign slot_free = ~out_valid | ~out_stall;
  assign finish    = (state == S_UPDATE) & slot_free;
  assign saturated = (count_rd == '1);
  assign count_new = saturated ? count_rd : count_rd + 1'b1;

  assign ram_we    = clearing | finish;
  assign ram_waddr = clearing ? clr_addr : AW'(cur_code);
  assign ram_wdata = clearing ? '0 : count_new;

  always_comb begin
    best_code_next  = best_code;
    best_count_next = best_count;
    if (!saturated && ((count_new > best_count) ||
                       ((count_new == best_count) && (cur_code > best_code)))) begin
      best_code_next  = cur_code;
      best_count_next = count_new;
    end
    period_inc          = period_counter + 1'b1;
    report              = (period_inc >= report_period);
    period_counter_next = report ? '0 : period_inc;
    if (best_count_next > COUNT_WIDTH'(mch_pkg::OUT_COUNT_MAX)) begin
      mode_count_sat = mch_pkg::OUT_COUNT_W'(mch_pkg::OUT_COUNT_MAX);
    end else begin
      mode_count_sat = mch_pkg::OUT_COUNT_W'(best_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_FETCH;
      clearing       <= 1'b1;
      clr_addr       <= '0;
      period_counter <= '0;
      best_code      <= '0;
      best_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (clearing && clr_addr == AW'(NUM_CODES - 1)) begin
        clearing <= 1'b0;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      unique case (state)
        S_FETCH: begin
          if (pop) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (finish) begin
            state <= S_FETCH;
          end
        end
        default: state <= S_FETCH;
      endcase
      if (finish) begin
        period_counter <= period_counter_next;
        best_code      <= best_code_next;
        best_count     <= best_count_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      cur_code <= head.code;
    end
    if (finish) begin
      country_code <= cur_code;
      report_valid <= report;
      mode_code    <= report ? best_code_next : '0;
      mode_count   <= report ? mode_count_sat : '0;
    end
  end

endmodule

/* rtl/core/mmsi_country_histogram_mode.sv */
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   vessel_id
// output    out        out_valid/out_stall country_code, report_valid, mode_code, mode_count
// config    in         cfg_we              cfg_data (report period)
//
// Front: takes an item, applies zero to three reciprocal-multiply steps (divide by 1000, 100
// or 10) until the code is below 1000, then pushes it into a two-entry queue.
// Back: per item a histogram RAM read then write on the single RAM port pair, one item at a time.
// Reset starts a clearing pass over all NUM_CODES histogram entries; no input transfer then.
// A stalled result holds in the output register while the back part fetches the next code.
module mmsi_country_histogram_mode #(
  parameter int NUM_CODES   = mch_pkg::NUM_CODES_DEF,
  parameter int COUNT_WIDTH = mch_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mch_pkg::PERIOD_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mch_pkg::ID_W-1:0]        vessel_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mch_pkg::CODE_W-1:0]      country_code,
  output logic                            report_valid,
  output logic [mch_pkg::CODE_W-1:0]      mode_code,
  output logic [mch_pkg::OUT_COUNT_W-1:0] mode_count
);

  logic [mch_pkg::PERIOD_W-1:0] report_period;
  mch_pkg::code_push_t          push;
  mch_pkg::code_head_t          head;
  logic                         queue_full;
  logic                         pop;
  logic                         clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period <= mch_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      report_period <= cfg_data;
    end
  end

  mch_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vessel_id  (vessel_id),
    .queue_full (queue_full),
    .push       (push)
  );

  mch_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  mch_back #(
    .NUM_CODES   (NUM_CODES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .report_period (report_period),
    .head          (head),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .country_code  (country_code),
    .report_valid  (report_valid),
    .mode_code     (mode_code),
    .mode_count    (mode_count)
  );

endmodule

/* rtl/core/mch_chk.sv */
module mch_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mch_pkg::CODE_W-1:0]      country_code,
  input logic                            report_valid,
  input logic [mch_pkg::CODE_W-1:0]      mode_code,
  input logic [mch_pkg::OUT_COUNT_W-1:0] mode_count
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(country_code) &&
      $stable(report_valid) && $stable(mode_code) && $stable(mode_count))
    else $error("stalled result changed");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> country_code < mch_pkg::CODE_W'(1000) && mode_code < mch_pkg::CODE_W'(1000))
    else $error("code out of range");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |-> mode_code == '0 && mode_count == '0)
    else $error("mode fields set without report");

  a_report_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> mode_count != '0)
    else $error("report with empty mode count");

endmodule

bind mmsi_country_histogram_mode mch_chk u_chk (.*);

/* tb/sv/tb_mmsi_country_histogram_mode.sv */
module tb_mmsi_country_histogram_mode;
  timeunit 1ns;
  timeprecision 1ps;

  import mch_pkg::*;

  localparam int          WATCHDOG_LIMIT = 8000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          LONG_HOLD      = 300;
  localparam int          PHASE_ITEMS    = 140;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          DIRECTED_ROWS  = 28;
  localparam int unsigned DIGIT_BASE     = 10;
  localparam logic [31:0] TALLY_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CODE_W-1:0]      code;
    logic                   report;
    logic [CODE_W-1:0]      mode_code;
    logic [OUT_COUNT_W-1:0] mode_count;
  } mode_report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [ID_W-1:0]     vessel;
    logic [PERIOD_W-1:0] period;
    logic                typed;
    mode_report_t        want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [PERIOD_W-1:0]    cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ID_W-1:0]        vessel_id = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CODE_W-1:0]      country_code;
  logic                   report_valid;
  logic [CODE_W-1:0]      mode_code;
  logic [OUT_COUNT_W-1:0] mode_count;

  logic [31:0]         code_tally [NUM_CODES_DEF];
  logic [PERIOD_W-1:0] items_in_period;
  logic [CODE_W-1:0]   lead_code;
  logic [31:0]         lead_count;
  logic [PERIOD_W-1:0] period_setting;

  mode_report_t pending_reports [$];

  int ids_sent      = 0;
  int results_seen  = 0;
  int reports_seen  = 0;
  int mismatches    = 0;
  int gap_pct       = 25;
  int stall_pct     = 10;
  bit no_idling     = 1'b0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  int fleet_codes [10] = '{230, 231, 244, 257, 273, 316, 338, 366, 412, 999};

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ITEM, 30'd0,          16'd0, 1'b1, '{10'd0,   1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd999,        16'd0, 1'b1, '{10'd999, 1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd1000,       16'd0, 1'b1, '{10'd100, 1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd999999999,  16'd0, 1'b1, '{10'd999, 1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'h3FFFFFFF,   16'd0, 1'b1, '{10'd107, 1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd123456789,  16'd0, 1'b1, '{10'd123, 1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd99,         16'd0, 1'b1, '{10'd99,  1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd1,          16'd0, 1'b1, '{10'd1,   1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd100000000,  16'd0, 1'b1, '{10'd100, 1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd536870912,  16'd0, 1'b1, '{10'd536, 1'b0, 10'd0, 32'd0}},
    '{ROW_ITEM, 30'd230123456,  16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd230999999,  16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd231000000,  16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd100,        16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd999000000,  16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd412345678,  16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd412000001,  16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd999,        16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd230,        16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd100,        16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd273000000,  16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd273111111,  16'd0, 1'b0, '0},
    '{ROW_CFG,  30'd0,          16'd1, 1'b0, '0},
    '{ROW_ITEM, 30'd5,          16'd0, 1'b0, '0},
    '{ROW_CFG,  30'd0,          16'd0, 1'b0, '0},
    '{ROW_ITEM, 30'd999999,     16'd0, 1'b0, '0},
    '{ROW_CFG,  30'd0,          16'd65535, 1'b0, '0},
    '{ROW_ITEM, 30'd338000000,  16'd0, 1'b0, '0}
  };

  mmsi_country_histogram_mode i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vessel_id    (vessel_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .country_code (country_code),
    .report_valid (report_valid),
    .mode_code    (mode_code),
    .mode_count   (mode_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic mode_report_t tally_vessel(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] v;
    logic [31:0]     n;
    mode_report_t    r;
    v = id;
    while (v >= CODE_LIMIT) v = ID_W'(v / DIGIT_BASE);
    r = '0;
    r.code = v[CODE_W-1:0];
    n = code_tally[r.code];
    if (n != TALLY_MAX) begin
      n = n + 1;
      code_tally[r.code] = n;
      if (n > lead_count || (n == lead_count && r.code > lead_code)) begin
        lead_count = n;
        lead_code  = r.code;
      end
    end
    items_in_period = items_in_period + 1'b1;
    if (items_in_period >= period_setting) begin
      items_in_period = '0;
      r.report        = 1'b1;
      r.mode_code     = lead_code;
      r.mode_count    = lead_count;
    end
    return r;
  endfunction

  function automatic logic [ID_W-1:0] random_vessel_id();
    int unsigned sel;
    int unsigned code;
    int unsigned scale;
    int unsigned digits;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      return ID_W'($urandom_range(1000000000, 32'h3FFF_FFFF));
    end else if (sel < 12) begin
      return ID_W'($urandom_range(0, 999));
    end else if (sel < 17) begin
      return ID_W'($urandom);
    end
    if (sel < 80) begin
      code = fleet_codes[$urandom_range(0, 9)];
    end else begin
      code = $urandom_range(100, 999);
    end
    digits = $urandom_range(0, 6);
    scale  = 1;
    repeat (digits) scale = scale * DIGIT_BASE;
    return ID_W'(code * scale + $urandom_range(0, scale - 1));
  endfunction

  task automatic send_id(input logic [ID_W-1:0] id, input logic typed, input mode_report_t want);
    mode_report_t predicted;
    in_valid  <= 1'b1;
    vessel_id <= id;
    do @(posedge clk); while (in_stall);
    predicted = tally_vessel(id);
    pending_reports.push_back(typed ? want : predicted);
    ids_sent++;
    if (!no_idling && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    period_setting = value;
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD;
      out_stall    <= 1'b1;
    end else if (no_idling) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 17);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    mode_report_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (report_valid) reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, country_code %0d", $time, country_code);
      end else begin
        want = pending_reports.pop_front();
        if (country_code !== want.code) begin
          mismatches++;
          $display("%0t: country_code expected %0d actual %0d", $time, want.code, country_code);
        end
        if (report_valid !== want.report) begin
          mismatches++;
          $display("%0t: report_valid expected %0d actual %0d", $time, want.report,
                   report_valid);
        end
        if (mode_code !== want.mode_code) begin
          mismatches++;
          $display("%0t: mode_code expected %0d actual %0d", $time, want.mode_code, mode_code);
        end
        if (mode_count !== want.mode_count) begin
          mismatches++;
          $display("%0t: mode_count expected %0d actual %0d", $time, want.mode_count,
                   mode_count);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_mmsi_country_histogram_mode NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [PERIOD_W-1:0] periods [RANDOM_PHASES];
    foreach (code_tally[i]) code_tally[i] = '0;
    items_in_period = '0;
    lead_code       = '0;
    lead_count      = '0;
    period_setting  = PERIOD_RESET;
    periods = '{16'd0, 16'd1, 16'd65535, 16'd2, 16'd13, 16'd3, 16'd41, 16'd20};
    periods[5] = PERIOD_W'($urandom_range(3, 40));
    periods[6] = PERIOD_W'($urandom_range(41, 65535));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_period(directed_rows[i].period);
      end else begin
        send_id(directed_rows[i].vessel, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_period(periods[ph]);
      case (ph % 3)
        0: begin
          gap_pct   = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct   = 10;
          stall_pct <= 15;
        end
        default: begin
          gap_pct   = 35;
          stall_pct <= 30;
        end
      endcase
      if (ph == 3) hold_requests <= hold_requests + 1;
      if (ph == RANDOM_PHASES - 1) no_idling <= 1'b1;
      repeat (PHASE_ITEMS) send_id(random_vessel_id(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d vessel ids sent, %0d results checked, %0d mode reports, %0d mismatches",
             ids_sent, results_seen, reports_seen, mismatches);
    $display("run: periods 0, 1, 2, 13, 20, 65535 and random, plus one long output hold");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb_mmsi_country_histogram_mode OK");
    end else begin
      $display("tb_mmsi_country_histogram_mode NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mch_pkg.sv
rtl/core/mch_ram.sv
rtl/core/mch_front.sv
rtl/core/mch_queue.sv
rtl/core/mch_back.sv
rtl/core/mmsi_country_histogram_mode.sv
rtl/core/mch_chk.sv
tb/sv/tb_mmsi_country_histogram_mode.sv
